>>> sv/lict_pkg.sv
// ---------------------------------------------------------------------------
// lict_pkg
// Shared types and register map of the local interrupt controller timer.
// ---------------------------------------------------------------------------
package lict_pkg;

    localparam int DataWidth = 32;
    localparam int OfsWidth  = 10;
    localparam int ReqWidth  = 2;

    // request codes
    localparam logic [ReqWidth-1:0] REQ_READ  = 2'd0;
    localparam logic [ReqWidth-1:0] REQ_WRITE = 2'd1;
    localparam logic [ReqWidth-1:0] REQ_TICK  = 2'd2;

    // register offsets
    localparam logic [OfsWidth-1:0] OFS_ID     = 10'h020;
    localparam logic [OfsWidth-1:0] OFS_VER    = 10'h030;
    localparam logic [OfsWidth-1:0] OFS_EOI    = 10'h0B0;
    localparam logic [OfsWidth-1:0] OFS_SVR    = 10'h0F0;
    localparam logic [OfsWidth-1:0] OFS_CMD_LO = 10'h300;
    localparam logic [OfsWidth-1:0] OFS_CMD_HI = 10'h310;
    localparam logic [OfsWidth-1:0] OFS_LVT    = 10'h320;
    localparam logic [OfsWidth-1:0] OFS_INIT   = 10'h380;
    localparam logic [OfsWidth-1:0] OFS_CUR    = 10'h390;
    localparam logic [OfsWidth-1:0] OFS_DIV    = 10'h3E0;

    // bit positions
    localparam int BIT_PERIODIC = 17;
    localparam int BIT_MASKED   = 16;
    localparam int BIT_BUSY     = 12;
    localparam int BIT_SWENABLE = 8;

    // configuration register indexes
    localparam logic CFG_CONTROLLER_ID  = 1'b0;
    localparam logic CFG_VERSION_NUMBER = 1'b1;

    localparam logic [7:0] VERSION_RESET = 8'd20;
    localparam logic [8:0] SVR_RESET     = 9'h0FF;

    typedef struct packed {
        logic [DataWidth-1:0] read_data;
        logic                 timer_irq;
        logic [7:0]           irq_vector;
        logic                 ipi_send;
        logic [7:0]           ipi_destination;
        logic [DataWidth-1:0] ipi_command;
        logic                 eoi_seen;
    } t_result;

endpackage

>>> sv/local_interrupt_controller_timer.sv
// Output: a result is registered in the output register or in the skid entry.
// Throughput: one item per cycle while o_in_stall is low; the timer and register update
// is a single pass of decode and one count decrement between state and result register.
// Reset: synchronous, active low; timer masked, one-shot, counts zero,
// spurious register 0xFF, version 20, no result pending.
// ---------------------------------------------------------------------------
// local_interrupt_controller_timer
// Timer and interprocessor-interrupt register block with APB configuration.
// ---------------------------------------------------------------------------
module local_interrupt_controller_timer #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [9:0]  i_reg_offset,
    input  logic [31:0] i_write_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_timer_irq,
    output logic [7:0]  o_irq_vector,
    output logic        o_ipi_send,
    output logic [7:0]  o_ipi_destination,
    output logic [31:0] o_ipi_command,
    output logic        o_eoi_seen,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lict_pkg::*;

    logic [7:0] r_ctrl_id;
    logic [7:0] r_version;
    logic       acc;
    logic       cfg_wr;
    t_result    core_res;
    t_result    out_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_id <= '0;
            r_version <= VERSION_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                CFG_CONTROLLER_ID:  r_ctrl_id <= pwdata[7:0];
                CFG_VERSION_NUMBER: r_version <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == CFG_CONTROLLER_ID) ? {24'd0, r_ctrl_id}
                                                     : {24'd0, r_version};

    assign acc = i_in_valid && !o_in_stall;

    lict_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_acc            (acc),
        .i_req_type       (i_req_type),
        .i_reg_offset     (i_reg_offset),
        .i_write_data     (i_write_data),
        .i_controller_id  (r_ctrl_id),
        .i_version_number (r_version),
        .o_result         (core_res)
    );

    lict_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_acc    (acc),
        .i_result (core_res),
        .o_full   (o_in_stall),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_res)
    );

    assign o_read_data       = out_res.read_data;
    assign o_timer_irq       = out_res.timer_irq;
    assign o_irq_vector      = out_res.irq_vector;
    assign o_ipi_send        = out_res.ipi_send;
    assign o_ipi_destination = out_res.ipi_destination;
    assign o_ipi_command     = out_res.ipi_command;
    assign o_eoi_seen        = out_res.eoi_seen;

endmodule

>>> sv/lict_core.sv
// ---------------------------------------------------------------------------
// lict_core
// Register state, decode and timer update; result is combinational from
// the current state and the item being accepted.
// ---------------------------------------------------------------------------
module lict_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic [lict_pkg::ReqWidth-1:0]   i_req_type,
    input  logic [lict_pkg::OfsWidth-1:0]   i_reg_offset,
    input  logic [lict_pkg::DataWidth-1:0]  i_write_data,
    input  logic [7:0]                      i_controller_id,
    input  logic [7:0]                      i_version_number,
    output lict_pkg::t_result               o_result
);
    import lict_pkg::*;

    logic [7:0]             r_lvt_vector,    n_lvt_vector;
    logic                   r_lvt_masked,    n_lvt_masked;
    logic                   r_lvt_periodic,  n_lvt_periodic;
    logic [COUNT_WIDTH-1:0] r_initial_count, n_initial_count;
    logic [COUNT_WIDTH-1:0] r_current_count, n_current_count;
    logic [3:0]             r_divide_code,   n_divide_code;
    logic [6:0]             r_prescale,      n_prescale;
    logic [8:0]             r_spurious,      n_spurious;
    logic [7:0]             r_icr_dest,      n_icr_dest;
    logic [31:0]            r_icr_low,       n_icr_low;
    logic                   r_busy,          n_busy;

    logic [2:0]             div_idx;
    logic [7:0]             ratio;
    logic [7:0]             pre_next;
    logic [COUNT_WIDTH-1:0] cnt_dec;
    logic [31:0]            cmd_rd;

    assign div_idx  = {r_divide_code[3], r_divide_code[1:0]};
    assign ratio    = (div_idx == 3'd7) ? 8'd1 : (8'd2 << div_idx);
    assign pre_next = {1'b0, r_prescale} + 8'd1;
    assign cnt_dec  = r_current_count - COUNT_WIDTH'(1);

    always_comb begin
        cmd_rd           = r_icr_low;
        cmd_rd[BIT_BUSY] = r_busy;
    end

    always_comb begin
        n_lvt_vector    = r_lvt_vector;
        n_lvt_masked    = r_lvt_masked;
        n_lvt_periodic  = r_lvt_periodic;
        n_initial_count = r_initial_count;
        n_current_count = r_current_count;
        n_divide_code   = r_divide_code;
        n_prescale      = r_prescale;
        n_spurious      = r_spurious;
        n_icr_dest      = r_icr_dest;
        n_icr_low       = r_icr_low;
        n_busy          = r_busy;
        o_result        = '0;

        unique case (i_req_type)
            REQ_READ: begin
                unique case (i_reg_offset)
                    OFS_ID:     o_result.read_data = {i_controller_id, 24'd0};
                    OFS_VER:    o_result.read_data = {24'd0, i_version_number};
                    OFS_SVR:    o_result.read_data = {23'd0, r_spurious};
                    OFS_CMD_LO: o_result.read_data = cmd_rd;
                    OFS_CMD_HI: o_result.read_data = {r_icr_dest, 24'd0};
                    OFS_LVT:    o_result.read_data = {14'd0, r_lvt_periodic, r_lvt_masked,
                                                      8'd0, r_lvt_vector};
                    OFS_INIT:   o_result.read_data = 32'(r_initial_count);
                    OFS_CUR:    o_result.read_data = 32'(r_current_count);
                    OFS_DIV:    o_result.read_data = {28'd0, r_divide_code};
                    default:    o_result.read_data = '0;
                endcase
            end
            REQ_WRITE: begin
                unique case (i_reg_offset)
                    OFS_EOI: o_result.eoi_seen = 1'b1;
                    OFS_SVR: n_spurious = i_write_data[8:0];
                    OFS_CMD_LO: begin
                        n_icr_low           = i_write_data;
                        n_icr_low[BIT_BUSY] = 1'b0;
                        n_busy              = 1'b1;
                        o_result.ipi_send        = 1'b1;
                        o_result.ipi_destination = r_icr_dest;
                        o_result.ipi_command     = i_write_data;
                    end
                    OFS_CMD_HI: n_icr_dest = i_write_data[31:24];
                    OFS_LVT: begin
                        n_lvt_vector   = i_write_data[7:0];
                        n_lvt_masked   = i_write_data[BIT_MASKED];
                        n_lvt_periodic = i_write_data[BIT_PERIODIC];
                    end
                    OFS_INIT: begin
                        n_initial_count = i_write_data[COUNT_WIDTH-1:0];
                        n_current_count = i_write_data[COUNT_WIDTH-1:0];
                        n_prescale      = '0;
                    end
                    OFS_DIV: n_divide_code = {i_write_data[3], 1'b0, i_write_data[1:0]};
                    default: ;
                endcase
            end
            REQ_TICK: begin
                n_busy = 1'b0;
                if (r_current_count != '0) begin
                    if (pre_next >= ratio) begin
                        n_prescale      = '0;
                        n_current_count = cnt_dec;
                        if (cnt_dec == '0) begin
                            if (!r_lvt_masked && r_spurious[BIT_SWENABLE]) begin
                                o_result.timer_irq  = 1'b1;
                                o_result.irq_vector = r_lvt_vector;
                            end
                            if (r_lvt_periodic)
                                n_current_count = r_initial_count;
                        end
                    end else begin
                        // next stays below ratio, which is at most 128
                        n_prescale = pre_next[6:0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvt_vector    <= '0;
            r_lvt_masked    <= 1'b1;
            r_lvt_periodic  <= 1'b0;
            r_initial_count <= '0;
            r_current_count <= '0;
            r_divide_code   <= '0;
            r_prescale      <= '0;
            r_spurious      <= SVR_RESET;
            r_icr_dest      <= '0;
            r_icr_low       <= '0;
            r_busy          <= 1'b0;
        end else if (i_acc) begin
            r_lvt_vector    <= n_lvt_vector;
            r_lvt_masked    <= n_lvt_masked;
            r_lvt_periodic  <= n_lvt_periodic;
            r_initial_count <= n_initial_count;
            r_current_count <= n_current_count;
            r_divide_code   <= n_divide_code;
            r_prescale      <= n_prescale;
            r_spurious      <= n_spurious;
            r_icr_dest      <= n_icr_dest;
            r_icr_low       <= n_icr_low;
            r_busy          <= n_busy;
        end
    end

endmodule

>>> sv/lict_out.sv
// ---------------------------------------------------------------------------
// lict_out
// Result register with one skid entry, so an item is taken while a result
// waits at the output.
// ---------------------------------------------------------------------------
module lict_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  lict_pkg::t_result i_result,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output lict_pkg::t_result o_result
);
    import lict_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // skid full means no item was accepted this cycle
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else if (i_acc) begin
                r_out        <= i_result;
                r_out_valid  <= 1'b1;
            end else begin
                r_out_valid  <= 1'b0;
            end
        end else if (i_acc) begin
            r_skid       <= i_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule
